/* rtl/core/pta_pkg.sv */
package pta_pkg;

  localparam int PORT_BITS       = 16;
  localparam int ADDRESS_BITS    = 64;
  localparam int PORT_FIELD_BITS = 16;
  localparam int ADDR_FIELD_BITS = 64;

  localparam int ROW_LOG       = (PORT_BITS - 1 < 5) ? PORT_BITS - 1 : 5;
  localparam int ROW_BITS      = 1 << ROW_LOG;
  localparam int ROW_ADDR_BITS = PORT_BITS - ROW_LOG;
  localparam int HALF_ROWS     = 1 << (ROW_ADDR_BITS - 1);
  localparam int ENTRY_BITS    = 1 + ADDRESS_BITS + PORT_FIELD_BITS;

  localparam logic [PORT_BITS-1:0] HALF_PORT  = PORT_BITS'(1) << (PORT_BITS - 1);
  localparam logic [PORT_BITS-1:0] LAST_RESET = HALF_PORT - PORT_BITS'(1);
  localparam logic [ROW_ADDR_BITS-1:0] HALF_ROW_BASE =
    ROW_ADDR_BITS'(1) << (ROW_ADDR_BITS - 1);

  typedef enum logic [2:0] {
    OP_OPEN    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_DELIVER = 3'd3,
    OP_QUERY   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EXISTS = 3'd1,
    ST_RANGE  = 3'd2,
    ST_FULL   = 3'd3,
    ST_NONE   = 3'd4,
    ST_KIND   = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]                 opcode;
    logic [PORT_FIELD_BITS-1:0] port_id;
    logic [ADDR_FIELD_BITS-1:0] node_address;
    logic [PORT_FIELD_BITS-1:0] node_port;
  } cmd_t;

  typedef struct packed {
    logic [2:0]                 status;
    logic [PORT_FIELD_BITS-1:0] assigned_port;
    logic [ADDR_FIELD_BITS-1:0] endpoint_address;
    logic [PORT_FIELD_BITS-1:0] endpoint_port;
  } rsp_t;

  function automatic logic [ROW_LOG-1:0] onehot_index(input logic [ROW_BITS-1:0] onehot);
    logic [ROW_LOG-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | ROW_LOG'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/core/pta_ram.sv */
module pta_ram #(
  parameter int ADDR_BITS = 11,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/port_table_allocator_unit.sv */
// Open, release, deliver and query: the word is looked up in S_LOOK and the result is
// registered there, or from S_HOLD while the output stalls; the next word is taken in S_IDLE.
// Allocate: the valid map is read one 32-port row per cycle and the result follows the last
// row scanned, up to 1025 rows for a full upper half. One word is in work at a time.
// Reset: a clearing pass zeroes the valid map, one row per cycle,
// with cmd_stall high; the last assigned port resets to 32767.
module port_table_allocator_unit
  import pta_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [ROW_ADDR_BITS-1:0]   clear_row, clear_row_next;
  logic [2:0]                 op;
  logic [PORT_FIELD_BITS-1:0] port;
  logic [ADDRESS_BITS-1:0]    raddr;
  logic [PORT_FIELD_BITS-1:0] rport;
  logic [PORT_BITS-1:0]       last_assigned, last_assigned_next;
  logic [ROW_ADDR_BITS-1:0]   scan_row, scan_row_next;
  logic [ROW_LOG-1:0]         scan_start, scan_start_next;
  logic [ROW_ADDR_BITS-1:0]   scan_left, scan_left_next;
  rsp_t                       pend;

  logic                     v_we;
  logic [ROW_ADDR_BITS-1:0] v_waddr, v_raddr;
  logic [ROW_BITS-1:0]      v_wdata, v_rdata;
  logic                     e_we;
  logic [PORT_BITS-1:0]     e_waddr, e_raddr;
  logic [ENTRY_BITS-1:0]    e_wdata, e_rdata;

  logic                 accept;
  logic                 out_free;
  logic                 fin;
  rsp_t                 fin_word;
  logic [PORT_BITS:0]   cand_wide;
  logic [PORT_BITS-1:0] cand;
  logic [ROW_BITS-1:0]  bit_mask;
  logic [ROW_BITS-1:0]  free;
  logic [ROW_BITS-1:0]  lowest;
  logic [ROW_ADDR_BITS-1:0] row_after;
  logic                 port_in_table;
  logic                 port_low;
  logic                 vbit;
  logic                 is_reply;

  pta_ram #(
    .ADDR_BITS(ROW_ADDR_BITS),
    .DATA_BITS(ROW_BITS)
  ) u_valid_map (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata(v_wdata),
    .raddr(v_raddr),
    .rdata(v_rdata)
  );

  pta_ram #(
    .ADDR_BITS(PORT_BITS),
    .DATA_BITS(ENTRY_BITS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign cand_wide = {1'b0, last_assigned} + (PORT_BITS + 1)'(1);
  assign cand      = cand_wide[PORT_BITS] ? HALF_PORT : cand_wide[PORT_BITS-1:0];

  assign bit_mask      = ROW_BITS'(1) << port[ROW_LOG-1:0];
  assign vbit          = v_rdata[port[ROW_LOG-1:0]];
  assign is_reply      = e_rdata[ENTRY_BITS-1];
  assign port_in_table = ((32'(port) >> PORT_BITS) == 32'd0);
  assign port_low      = ((32'(port) >> (PORT_BITS - 1)) == 32'd0);
  assign free          = ~v_rdata & ({ROW_BITS{1'b1}} << scan_start);
  assign lowest        = free & (~free + ROW_BITS'(1));
  assign row_after     = ((scan_row + ROW_ADDR_BITS'(1)) == '0) ? HALF_ROW_BASE
                                                               : scan_row + ROW_ADDR_BITS'(1);

  always_comb begin
    state_next         = state;
    clear_row_next     = clear_row;
    last_assigned_next = last_assigned;
    scan_row_next      = scan_row;
    scan_start_next    = scan_start;
    scan_left_next     = scan_left;
    v_we               = 1'b0;
    v_waddr            = port[PORT_BITS-1:ROW_LOG];
    v_wdata            = v_rdata;
    v_raddr            = cmd.port_id[PORT_BITS-1:ROW_LOG];
    e_we               = 1'b0;
    e_waddr            = port[PORT_BITS-1:0];
    e_wdata            = {1'b0, raddr, rport};
    e_raddr            = cmd.port_id[PORT_BITS-1:0];
    fin                = 1'b0;
    fin_word           = '0;

    case (state)
      S_CLEAR: begin
        v_we           = 1'b1;
        v_waddr        = clear_row;
        v_wdata        = '0;
        clear_row_next = clear_row + ROW_ADDR_BITS'(1);
        if (&clear_row) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.opcode == OP_ALLOC) begin
            v_raddr         = cand[PORT_BITS-1:ROW_LOG];
            scan_row_next   = cand[PORT_BITS-1:ROW_LOG];
            scan_start_next = cand[ROW_LOG-1:0];
            scan_left_next  = ROW_ADDR_BITS'(HALF_ROWS - 1)
                            + ROW_ADDR_BITS'(cand[ROW_LOG-1:0] != '0);
            state_next      = S_SCAN;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        fin = 1'b1;
        case (op)
          OP_OPEN: begin
            if (!port_low) begin
              fin_word.status = ST_RANGE;
            end else if (vbit) begin
              fin_word.status        = ST_EXISTS;
              fin_word.assigned_port = port;
            end else begin
              v_we                   = 1'b1;
              v_wdata                = v_rdata | bit_mask;
              e_we                   = 1'b1;
              e_wdata                = {1'b0, raddr, rport};
              fin_word.status        = ST_OK;
              fin_word.assigned_port = port;
            end
          end
          OP_RELEASE, OP_DELIVER, OP_QUERY: begin
            if (!port_in_table) begin
              fin_word.status = ST_RANGE;
            end else if (!vbit) begin
              fin_word.status        = ST_NONE;
              fin_word.assigned_port = port;
            end else if (op == OP_RELEASE) begin
              v_we                   = 1'b1;
              v_wdata                = v_rdata & ~bit_mask;
              fin_word.status        = ST_OK;
              fin_word.assigned_port = port;
            end else if (op == OP_DELIVER) begin
              fin_word.status        = is_reply ? ST_KIND : ST_OK;
              fin_word.assigned_port = port;
            end else if (!is_reply) begin
              fin_word.status        = ST_KIND;
              fin_word.assigned_port = port;
            end else begin
              fin_word.status           = ST_OK;
              fin_word.assigned_port    = port;
              fin_word.endpoint_address =
                ADDR_FIELD_BITS'(e_rdata[PORT_FIELD_BITS +: ADDRESS_BITS]);
              fin_word.endpoint_port    = e_rdata[PORT_FIELD_BITS-1:0];
            end
          end
          default: begin
            fin_word.status = ST_RANGE;
          end
        endcase
      end
      S_SCAN: begin
        if (|free) begin
          v_we                   = 1'b1;
          v_waddr                = scan_row;
          v_wdata                = v_rdata | lowest;
          e_we                   = 1'b1;
          e_waddr                = {scan_row, onehot_index(lowest)};
          e_wdata                = {1'b1, raddr, rport};
          last_assigned_next     = {scan_row, onehot_index(lowest)};
          fin                    = 1'b1;
          fin_word.status        = ST_OK;
          fin_word.assigned_port = PORT_FIELD_BITS'({scan_row, onehot_index(lowest)});
        end else if (scan_left == '0) begin
          fin             = 1'b1;
          fin_word.status = ST_FULL;
        end else begin
          v_raddr         = row_after;
          scan_row_next   = row_after;
          scan_start_next = '0;
          scan_left_next  = scan_left - ROW_ADDR_BITS'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase

    if (fin) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clear_row     <= '0;
      last_assigned <= LAST_RESET;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clear_row     <= clear_row_next;
      last_assigned <= last_assigned_next;
      if ((fin || state == S_HOLD) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_row   <= scan_row_next;
    scan_start <= scan_start_next;
    scan_left  <= scan_left_next;
    if (accept) begin
      op    <= cmd.opcode;
      port  <= cmd.port_id;
      raddr <= cmd.node_address[ADDRESS_BITS-1:0];
      rport <= cmd.node_port;
    end
    if (fin && out_free) begin
      rsp <= fin_word;
    end else if (state == S_HOLD && out_free) begin
      rsp <= pend;
    end
    if (fin && !out_free) begin
      pend <= fin_word;
    end
  end

  a_last_upper: assert property (@(posedge clk) disable iff (rst)
    last_assigned[PORT_BITS-1] || (last_assigned == LAST_RESET))
    else $error("last assigned port left the upper half");

  a_scan_upper: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> scan_row[ROW_ADDR_BITS-1])
    else $error("search row outside the upper half");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state == S_LOOK || state == S_SCAN))
    else $error("accepted word not taken into work");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_HOLD) |-> (!v_we && !e_we))
    else $error("table written outside an operation");

  a_fin_slot: assert property (@(posedge clk) disable iff (rst)
    (fin && !out_free) |=> (state == S_HOLD && rsp_valid))
    else $error("finished word lost while output was stalled");

endmodule
